/* rtl/tcw_pkg.sv */
// Shared constants and types for the text console character writer.
`timescale 1ns / 1ps
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int NCELLS  = COLUMNS * ROWS;

    // Internal widths follow from the geometry
    localparam int ADDR_W = $clog2(NCELLS);
    localparam int CW     = $clog2(COLUMNS + 8);
    localparam int RW     = $clog2(ROWS + 1);

    // Port field widths
    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 4;
    localparam int IDX_W     = 11;
    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 5;
    localparam int LOC_W     = 11;
    localparam int CELL_W    = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam int TAB_STOP = 8;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    // Result of interpreting one character against the cursor
    typedef struct packed {
        logic [CW-1:0] col;
        logic [RW-1:0] row;
        logic          wr_en;
        logic          scroll;
    } t_step;

endpackage

/* rtl/tcw_cursor_step.sv */
// Cursor motion for one put character: controls, printable write, wrap, scroll.
`timescale 1ns / 1ps
module tcw_cursor_step (
    input  logic [tcw_pkg::CW-1:0]     i_col,
    input  logic [tcw_pkg::RW-1:0]     i_row,
    input  logic [tcw_pkg::CHAR_W-1:0] i_char_code,
    output tcw_pkg::t_step             o_step
);
    import tcw_pkg::*;

    logic [CW-1:0] col;
    logic [RW-1:0] row;
    logic          wr_en;

    always_comb begin
        col   = i_col;
        row   = i_row;
        wr_en = 1'b0;
        case (i_char_code)
            CH_BS: begin
                if (i_col != '0) begin
                    col = i_col - CW'(1);
                end
            end
            CH_TAB: begin
                col = (i_col + CW'(TAB_STOP)) & ~CW'(TAB_STOP - 1);
            end
            CH_CR: begin
                col = '0;
            end
            CH_LF: begin
                col = '0;
                row = i_row + RW'(1);
            end
            default: begin
                // high bytes are negative as signed char and fall out here
                if (i_char_code >= CH_SPACE && !i_char_code[CHAR_W-1]) begin
                    wr_en = 1'b1;
                    col   = i_col + CW'(1);
                end
            end
        endcase

        if (col >= CW'(COLUMNS)) begin
            col = '0;
            row = row + RW'(1);
        end

        o_step.wr_en  = wr_en;
        o_step.scroll = (row >= RW'(ROWS));
        o_step.col    = col;
        o_step.row    = (row >= RW'(ROWS)) ? RW'(ROWS - 1) : row;
    end

endmodule

/* rtl/text_console_character_writer.sv */
// Text console top level: cell memory, cursor and request sequencing.
//
//  channel   | valid        | stall        | payload
//  ----------+--------------+--------------+--------------------------------------------
//  request   | i_in_valid   | o_in_stall   | i_op i_char_code i_back_color i_fore_color
//            |              |              | i_cell_index
//  result    | o_out_valid  | i_out_stall  | o_cursor_col o_cursor_row o_cursor_location
//            |              |              | o_cell_value
//
// Put without scroll, the unused op code and out-of-range reads answer from the idle state.
// A cell read goes through S_READ (registered memory read). A put that scrolls goes through
// S_SCROLL, blanking one row, one cell per cycle; rows rotate through a base offset, nothing
// is copied. Clear blanks every cell in S_CLEAR before it answers. After reset a clearing
// pass over all NCELLS cells (2000) runs before the first request is taken. One request is
// in work at a time; a held result stalls acceptance only while the result side stalls.
`timescale 1ns / 1ps
module text_console_character_writer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [tcw_pkg::OP_W-1:0]        i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]      i_char_code,
    input  logic [tcw_pkg::COLOR_W-1:0]     i_back_color,
    input  logic [tcw_pkg::COLOR_W-1:0]     i_fore_color,
    input  logic [tcw_pkg::IDX_W-1:0]       i_cell_index,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [tcw_pkg::COL_OUT_W-1:0]   o_cursor_col,
    output logic [tcw_pkg::ROW_OUT_W-1:0]   o_cursor_row,
    output logic [tcw_pkg::LOC_W-1:0]       o_cursor_location,
    output logic [tcw_pkg::CELL_W-1:0]      o_cell_value
);
    import tcw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_SCROLL = 4'b0100,
        S_CLEAR  = 4'b1000
    } t_state;

    // logical cell address -> physical, rotated by the scroll base
    function automatic logic [ADDR_W-1:0] map_addr(input logic [ADDR_W-1:0] logical,
                                                   input logic [ADDR_W-1:0] base);
        logic [ADDR_W:0] sum;
        sum = {1'b0, logical} + {1'b0, base};
        if (sum >= (ADDR_W + 1)'(NCELLS)) begin
            sum = sum - (ADDR_W + 1)'(NCELLS);
        end
        return sum[ADDR_W-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cur_col, n_col;
    logic [RW-1:0]       r_cur_row, n_row;
    logic [ADDR_W-1:0]   r_base_off, n_base;
    logic [ADDR_W-1:0]   r_sweep, n_sweep;
    logic                r_clr_reply, n_clr_reply;

    logic                r_out_valid;
    logic [COL_OUT_W-1:0] r_out_col;
    logic [ROW_OUT_W-1:0] r_out_row;
    logic [LOC_W-1:0]    r_out_loc;
    logic [CELL_W-1:0]   r_out_value;

    logic [CELL_W-1:0]   r_screen_mem [NCELLS];
    logic [CELL_W-1:0]   r_rd_data;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    logic                in_accept;
    logic                out_free;
    logic                load_out;
    logic [CELL_W-1:0]   out_value;
    logic [ADDR_W-1:0]   cur_addr;
    logic [ADDR_W-1:0]   out_loc;
    t_step               step;

    tcw_cursor_step u_step (
        .i_col       (r_cur_col),
        .i_row       (r_cur_row),
        .i_char_code (i_char_code),
        .o_step      (step)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign cur_addr = ADDR_W'(r_cur_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_cur_col);
    assign out_loc  = ADDR_W'(n_row) * ADDR_W'(COLUMNS) + ADDR_W'(n_col);

    always_comb begin
        n_state     = r_state;
        n_col       = r_cur_col;
        n_row       = r_cur_row;
        n_base      = r_base_off;
        n_sweep     = r_sweep;
        n_clr_reply = r_clr_reply;
        mem_we      = 1'b0;
        mem_waddr   = r_sweep;
        mem_wdata   = BLANK_CELL;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        load_out    = 1'b0;
        out_value   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (i_op)
                        OP_PUT: begin
                            n_col     = step.col;
                            n_row     = step.row;
                            mem_we    = step.wr_en;
                            mem_waddr = map_addr(cur_addr, r_base_off);
                            mem_wdata = {i_back_color, i_fore_color, i_char_code};
                            if (step.scroll) begin
                                n_sweep = '0;
                                n_state = S_SCROLL;
                            end else begin
                                load_out = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_col       = '0;
                            n_row       = '0;
                            n_base      = '0;
                            n_sweep     = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_CLEAR;
                        end
                        OP_READ: begin
                            if (32'(i_cell_index) < NCELLS) begin
                                mem_re    = 1'b1;
                                mem_raddr = map_addr(ADDR_W'(i_cell_index), r_base_off);
                                n_state   = S_READ;
                            end else begin
                                load_out = 1'b1;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                out_value = r_rd_data;
                load_out  = 1'b1;
                n_state   = S_IDLE;
            end
            S_SCROLL: begin
                // old top row becomes the new bottom row; base stays row aligned
                mem_we    = 1'b1;
                mem_waddr = r_base_off + r_sweep;
                if (r_sweep == ADDR_W'(COLUMNS - 1)) begin
                    n_base   = (r_base_off == ADDR_W'(NCELLS - COLUMNS)) ? '0
                             : r_base_off + ADDR_W'(COLUMNS);
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep;
                if (r_sweep == ADDR_W'(NCELLS - 1)) begin
                    load_out    = r_clr_reply;
                    n_clr_reply = 1'b0;
                    n_state     = S_IDLE;
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_base_off  <= '0;
            r_sweep     <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_col   <= n_col;
            r_cur_row   <= n_row;
            r_base_off  <= n_base;
            r_sweep     <= n_sweep;
            r_clr_reply <= n_clr_reply;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_col   <= COL_OUT_W'(n_col);
            r_out_row   <= ROW_OUT_W'(n_row);
            r_out_loc   <= LOC_W'(out_loc);
            r_out_value <= out_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_screen_mem[mem_raddr];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cursor_col      = r_out_col;
    assign o_cursor_row      = r_out_row;
    assign o_cursor_location = r_out_loc;
    assign o_cell_value      = r_out_value;

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("request taken while sequencer busy");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_col < CW'(COLUMNS)) && (r_cur_row < RW'(ROWS)))
        else $error("cursor left the screen");

    a_base_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base_off <= ADDR_W'(NCELLS - COLUMNS))
        else $error("scroll base out of range");

    a_read_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> o_out_valid)
        else $error("cell read gave no result");

endmodule
